FILE: rtl/least_used_open_slot_policy_core_assert.svh
// Assertion macros for the least-used open-slot policy core.
// Used only by the top level; the macros assume clock i_clk and reset i_rst_n.
`ifndef LEAST_USED_OPEN_SLOT_POLICY_CORE_ASSERT_SVH
`define LEAST_USED_OPEN_SLOT_POLICY_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// cond holds at every edge out of reset
`define LUOS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("luos: invariant violated");
// ante implies cons in the same cycle
`define LUOS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("luos: implication violated");
// ante implies cons in the next cycle
`define LUOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("luos: sequence violated");
`else
`define LUOS_ASSERT_ALWAYS(label, cond)
`define LUOS_ASSERT_IMPLY(label, ante, cons)
`define LUOS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/luos_pkg.sv
// Shared types and constants for the least-used open-slot policy core.
// No dependencies; imported by the top level and luos_cmp, not by luos_ram.
package luos_pkg;

    localparam int DEF_SLOTS      = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int NUM_BITS       = 32;
    localparam int LIMIT_BITS     = 5;
    localparam int SLOT_BITS      = 4;
    localparam int OP_BITS        = 2;
    localparam int STS_BITS       = 2;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 16;
    localparam int OUT_PAD_W      = OUT_TDATA_W - 2 * SLOT_BITS - 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd4;

    // item kinds
    localparam logic [OP_BITS-1:0] OP_DEFINE  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd2;

    // result status codes
    localparam logic [STS_BITS-1:0] STS_OK    = 2'd0;
    localparam logic [STS_BITS-1:0] STS_UNDEF = 2'd1;
    localparam logic [STS_BITS-1:0] STS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PLAN,
        S_MIN,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

FILE: rtl/least_used_open_slot_policy_core.sv
// Top level of the least-used open-slot policy core: sequencer, entry flags,
// output register. Uses luos_pkg, luos_ram, luos_cmp and the assert header.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tuser: op; tdata: resource_number, mark_missing
//  m_axis    | out       | tuser: status; tdata: slot, already_open,
//            |           |        evicted, evicted_slot
//  cfg       | in        | open_limit, written when i_cfg_we is high
//
// A define, clear or unused op goes from idle to commit, then to out, where
// its result loads into the m_axis register. A request runs a lookup scan,
// a plan step, a minimum-count scan only when a close is needed, then commit
// and out; each scan reads one slot a cycle from the RAMs. The next item can
// be taken in the cycle after the result loads, which waits on output stalls.
// Reset is synchronous; it clears flags and totals, sets the limit to 4. The
// RAMs need no clearing, as define writes a slot before a read of it is used.
// s_axis_tready is high only in idle; a result waiting on m_axis does not
// block the next item until that item's own result is ready.
`include "least_used_open_slot_policy_core_assert.svh"

module least_used_open_slot_policy_core
    import luos_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] resource_number, [32] mark_missing
    input  logic [OP_BITS-1:0]     s_axis_tuser,  // [1:0] op
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [3:0] slot, [4] already_open,
                                                  // [5] evicted, [9:6] evicted_slot
    output logic [STS_BITS-1:0]    m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                   i_cfg_we,
    input  logic [LIMIT_BITS-1:0]  i_cfg_wdata     // open_limit
);

    localparam int IW   = $clog2(SLOTS);
    localparam int TW   = $clog2(SLOTS + 1);
    localparam int CMPW = (TW > LIMIT_BITS) ? TW : LIMIT_BITS;
    localparam int EXW  = IW + SLOT_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // ---- state -------------------------------------------------------------
    t_state r_state, n_state;

    logic [OP_BITS-1:0]    r_op;
    logic [NUM_BITS-1:0]   r_num;
    logic                  r_miss;
    logic [LIMIT_BITS-1:0] r_limit;

    logic [SLOTS-1:0] r_ent_valid, n_ent_valid;
    logic [SLOTS-1:0] r_num_valid, n_num_valid;
    logic [SLOTS-1:0] r_missing,   n_missing;
    logic [SLOTS-1:0] r_open,      n_open;
    logic [TW-1:0]    r_def_total, n_def_total;
    logic [TW-1:0]    r_open_total, n_open_total;

    // scan sequencer
    logic [IW-1:0] r_idx;
    logic          r_issue_done;
    logic          r_pv;
    logic [IW-1:0] r_pidx;

    // scan results
    logic                  r_found;
    logic [IW-1:0]         r_hit;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_have;
    logic [IW-1:0]         r_best;
    logic [COUNT_BITS-1:0] r_best_cnt;

    // finished result, then output register
    logic [OUT_TDATA_W-1:0] r_res_tdata;
    logic [STS_BITS-1:0]    r_res_tuser;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic [STS_BITS-1:0]    r_m_tuser;

    // ---- control decode --------------------------------------------------
    logic accept, issue_en, commit_en, out_load, look_phase, min_phase;
    logic scan_start, scan_end, need_min;

    // ---- RAMs and shared compare ------------------------------------------
    logic [NUM_BITS-1:0]   num_q;
    logic [COUNT_BITS-1:0] cnt_q;
    logic                  num_we, cnt_we;
    logic [IW-1:0]         num_waddr, cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_bumped;
    logic [NUM_BITS-1:0]   cmp_a, cmp_b;
    t_cmp_res              cmp_res;
    logic                  look_hit, min_take;

    // result fields before packing
    logic [STS_BITS-1:0]  res_status;
    logic [IW-1:0]        res_slot_idx, res_ev_idx;
    logic                 res_served, res_ev;
    logic [EXW-1:0]       slot_ext, ev_ext;

    luos_ram #(.DEPTH(SLOTS), .WIDTH(NUM_BITS)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (num_we),
        .i_waddr (num_waddr),
        .i_wdata (r_num),
        .i_raddr (r_idx),
        .o_rdata (num_q)
    );

    luos_ram #(.DEPTH(SLOTS), .WIDTH(COUNT_BITS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_idx),
        .o_rdata (cnt_q)
    );

    // lookup compares stored number to the request; min scan compares counts
    assign cmp_a = look_phase ? num_q : NUM_BITS'(cnt_q);
    assign cmp_b = look_phase ? r_num : NUM_BITS'(r_best_cnt);

    luos_cmp #(.W(NUM_BITS)) u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    // scan walks from the newest slot down; first live match wins, and
    // strict less-than keeps the newest slot on a count tie
    assign look_hit = look_phase && r_pv && !r_found && r_ent_valid[r_pidx]
                      && r_num_valid[r_pidx] && cmp_res.eq;
    assign min_take = min_phase && r_pv && r_open[r_pidx] && (!r_have || cmp_res.lt);
    assign scan_end = r_pv && (r_pidx == '0);

    // a close is needed only when a closed, present entry is to be opened
    // with the open count at or above the limit
    assign need_min = r_found && !r_open[r_hit] && !r_missing[r_hit]
                      && (CMPW'(r_open_total) >= CMPW'(r_limit));

    assign accept = s_axis_tvalid && s_axis_tready;

    // ---- FSM: next state ---------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == OP_REQUEST) ? S_LOOK : S_COMMIT;
                end
            end
            S_LOOK: begin
                if (scan_end) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = need_min ? S_MIN : S_COMMIT;
            end
            S_MIN: begin
                if (scan_end) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- FSM: outputs ------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        issue_en      = 1'b0;
        commit_en     = 1'b0;
        out_load      = 1'b0;
        look_phase    = 1'b0;
        min_phase     = 1'b0;
        scan_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                scan_start    = s_axis_tvalid;
            end
            S_LOOK: begin
                issue_en   = !r_issue_done;
                look_phase = 1'b1;
            end
            S_PLAN: begin
                scan_start = need_min;
            end
            S_MIN: begin
                issue_en  = !r_issue_done;
                min_phase = 1'b1;
            end
            S_COMMIT: begin
                commit_en = 1'b1;
            end
            S_OUT: begin
                out_load = !r_m_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- input capture and config -----------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= s_axis_tuser;
            r_num  <= s_axis_tdata[NUM_BITS-1:0];
            r_miss <= s_axis_tdata[NUM_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // ---- scan sequencer: issue address, then compare in the next cycle -----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_done <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            if (scan_start) begin
                r_issue_done <= 1'b0;
            end else if (issue_en && (r_idx == '0)) begin
                r_issue_done <= 1'b1;
            end
            r_pv <= issue_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_start) begin
            r_idx <= LAST_IDX;
        end else if (issue_en && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
        r_pidx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            if (accept) begin
                r_found <= 1'b0;
                r_have  <= 1'b0;
            end else begin
                if (look_hit) begin
                    r_found <= 1'b1;
                end
                if (min_take) begin
                    r_have <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (look_hit) begin
            r_hit     <= r_pidx;
            r_hit_cnt <= cnt_q;
        end
        if (min_take) begin
            r_best     <= r_pidx;
            r_best_cnt <= cnt_q;
        end
    end

    // saturating count bump
    assign cnt_bumped = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + 1'b1;

    // ---- commit: table update and result fields ---------------------------
    always_comb begin
        n_ent_valid  = r_ent_valid;
        n_num_valid  = r_num_valid;
        n_missing    = r_missing;
        n_open       = r_open;
        n_def_total  = r_def_total;
        n_open_total = r_open_total;
        num_we       = 1'b0;
        num_waddr    = r_def_total[IW-1:0];
        cnt_we       = 1'b0;
        cnt_waddr    = r_hit;
        cnt_wdata    = cnt_bumped;
        res_status   = STS_OK;
        res_slot_idx = '0;
        res_served   = 1'b0;
        res_ev       = 1'b0;
        res_ev_idx   = '0;
        if (commit_en) begin
            case (r_op)
                OP_DEFINE: begin
                    if (r_def_total >= TW'(SLOTS)) begin
                        res_status = STS_FULL;
                    end else begin
                        num_we                    = 1'b1;
                        cnt_we                    = 1'b1;
                        cnt_waddr                 = r_def_total[IW-1:0];
                        cnt_wdata                 = '0;
                        n_ent_valid[num_waddr]    = 1'b1;
                        n_num_valid[num_waddr]    = 1'b1;
                        n_missing[num_waddr]      = r_miss;
                        n_open[num_waddr]         = 1'b0;
                        n_def_total               = r_def_total + 1'b1;
                        res_slot_idx              = r_def_total[IW-1:0];
                    end
                end
                OP_REQUEST: begin
                    if (!r_found) begin
                        res_status = STS_UNDEF;
                    end else if (r_open[r_hit] || r_missing[r_hit]) begin
                        cnt_we       = 1'b1;
                        res_served   = 1'b1;
                        res_slot_idx = r_hit;
                    end else begin
                        // close the least-used open slot first, if the scan ran
                        if (r_have) begin
                            n_open[r_best] = 1'b0;
                            res_ev         = 1'b1;
                            res_ev_idx     = r_best;
                        end
                        n_open[r_hit] = 1'b1;
                        cnt_we        = 1'b1;
                        res_slot_idx  = r_hit;
                        n_open_total  = r_have ? r_open_total : r_open_total + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_num_valid = '0;
                end
                default: begin
                    res_status = STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid  <= '0;
            r_num_valid  <= '0;
            r_missing    <= '0;
            r_open       <= '0;
            r_def_total  <= '0;
            r_open_total <= '0;
        end else begin
            r_ent_valid  <= n_ent_valid;
            r_num_valid  <= n_num_valid;
            r_missing    <= n_missing;
            r_open       <= n_open;
            r_def_total  <= n_def_total;
            r_open_total <= n_open_total;
        end
    end

    // slot fields carry the low four bits of the index
    assign slot_ext = EXW'(res_slot_idx);
    assign ev_ext   = EXW'(res_ev_idx);

    always_ff @(posedge i_clk) begin
        if (commit_en) begin
            r_res_tdata <= {{OUT_PAD_W{1'b0}}, ev_ext[SLOT_BITS-1:0], res_ev,
                            res_served, slot_ext[SLOT_BITS-1:0]};
            r_res_tuser <= res_status;
        end
    end

    // ---- output register ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= r_res_tdata;
            r_m_tuser <= r_res_tuser;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // ---- assertions --------------------------------------------------------
    `LUOS_ASSERT_ALWAYS(a_open_total_match, $countones(r_open) == int'(r_open_total))
    `LUOS_ASSERT_ALWAYS(a_open_is_defined, (r_open & ~r_ent_valid) == {SLOTS{1'b0}})
    `LUOS_ASSERT_NEXT(a_busy_after_accept, accept, r_state != S_IDLE)
    `LUOS_ASSERT_IMPLY(a_evict_from_open, commit_en && r_have, r_open[r_best] && (r_open_total != '0))

endmodule

FILE: rtl/luos_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing; holds entry numbers and use counts.
module luos_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/luos_cmp.sv
// Shared compare unit: equality for the number lookup, less-than for the
// minimum-count scan. Uses luos_pkg for the result struct.
module luos_cmp
    import luos_pkg::*;
#(
    parameter int W = NUM_BITS
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_cmp_res     o_res
);

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

FILE: verif/tb_least_used_open_slot_policy_core.sv
// Self-checking testbench for least_used_open_slot_policy_core: stream driver and
// monitor around a cycle-free model of the define / request / clear policy.
// Depends on luos_pkg and the RTL of the core; reads no files.
`timescale 1ns / 100ps

module tb_least_used_open_slot_policy_core;
    import luos_pkg::*;

    localparam int SLOTS       = DEF_SLOTS;
    localparam int COUNT_BITS  = DEF_COUNT_BITS;
    localparam int CYCLE_LIMIT = 1_000_000;
    // longest item is a request with a close
    localparam int TAIL_CYCLES = 2 * SLOTS + 8;

    // op code the block leaves unused; it must answer with an all-zero item
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [NUM_BITS-1:0] number;
        logic                missing;
        logic                drain_first;  // sender holds until every result is back
    } slot_item_t;

    typedef struct packed {
        logic [STS_BITS-1:0]  status;
        logic [SLOT_BITS-1:0] slot;
        logic                 served;
        logic                 evicted;
        logic [SLOT_BITS-1:0] evicted_slot;
    } slot_result_t;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] resource_number, [32] mark_missing
    logic [OP_BITS-1:0]     s_axis_tuser  = '0;  // [1:0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [3:0] slot, [4] already_open,
                                                 // [5] evicted, [9:6] evicted_slot
    logic [STS_BITS-1:0]    m_axis_tuser;        // [1:0] status
    logic                   i_cfg_we      = 1'b0;
    logic [LIMIT_BITS-1:0]  i_cfg_wdata   = LIMIT_RESET;

    least_used_open_slot_policy_core #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    int unsigned cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Policy tracker: mirror of the slot table, updated per accepted item
    // ------------------------------------------------------------------
    logic [NUM_BITS-1:0]   ent_number  [SLOTS];
    logic                  ent_used    [SLOTS];
    logic                  ent_live    [SLOTS];  // number still valid (no clear since)
    logic                  ent_missing [SLOTS];
    logic                  ent_open    [SLOTS];
    logic [COUNT_BITS-1:0] ent_uses    [SLOTS];
    int                    open_cnt     = 0;
    int                    defined_cnt  = 0;
    logic [LIMIT_BITS-1:0] open_limit_now = LIMIT_RESET;

    slot_item_t   pending_items[$];
    slot_result_t expected_results[$];
    logic [NUM_BITS-1:0] known_numbers[$];  // numbers that were actually defined
    int           defines_queued = 0;
    int           err_count      = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    function automatic slot_result_t apply_policy(input slot_item_t it);
        slot_result_t r;
        int           s;
        int           hit;
        int           best;
        bit           found;
        bit           have;
        r     = '0;
        hit   = 0;
        best  = 0;
        found = 1'b0;
        have  = 1'b0;
        case (it.op)
            OP_DEFINE: begin
                if (defined_cnt >= SLOTS) begin
                    r.status = STS_FULL;
                end else begin
                    ent_number[defined_cnt]  = it.number;
                    ent_used[defined_cnt]    = 1'b1;
                    ent_live[defined_cnt]    = 1'b1;
                    ent_missing[defined_cnt] = it.missing;
                    ent_open[defined_cnt]    = 1'b0;
                    ent_uses[defined_cnt]    = '0;
                    r.slot = SLOT_BITS'(defined_cnt);
                    defined_cnt++;
                end
            end
            OP_REQUEST: begin
                // newest (highest index) match wins
                for (s = SLOTS - 1; s >= 0; s--) begin
                    if (!found && ent_used[s] && ent_live[s] && ent_number[s] == it.number) begin
                        found = 1'b1;
                        hit   = s;
                    end
                end
                if (!found) begin
                    r.status = STS_UNDEF;
                end else if (ent_open[hit] || ent_missing[hit]) begin
                    if (ent_uses[hit] != '1) ent_uses[hit] = ent_uses[hit] + 1'b1;
                    r.slot   = SLOT_BITS'(hit);
                    r.served = 1'b1;
                end else begin
                    if (open_cnt >= open_limit_now) begin
                        // smallest count among open entries, ties to the newest
                        for (s = SLOTS - 1; s >= 0; s--) begin
                            if (ent_open[s] && (!have || ent_uses[s] < ent_uses[best])) begin
                                best = s;
                                have = 1'b1;
                            end
                        end
                        if (have) begin
                            ent_open[best] = 1'b0;
                            if (open_cnt > 0) open_cnt--;
                            r.evicted      = 1'b1;
                            r.evicted_slot = SLOT_BITS'(best);
                        end
                    end
                    ent_open[hit] = 1'b1;
                    if (ent_uses[hit] != '1) ent_uses[hit] = ent_uses[hit] + 1'b1;
                    open_cnt++;
                    r.slot = SLOT_BITS'(hit);
                end
            end
            OP_CLEAR: begin
                for (s = 0; s < SLOTS; s++) ent_live[s] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one item in flight on s_axis; prediction at the accept edge
    // ------------------------------------------------------------------
    slot_item_t cur_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_policy(cur_item));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && expected_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({cur_item.missing, cur_item.number});
                    s_axis_tuser  <= cur_item.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, in-order compare against predictions
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        slot_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item pending: status %0d, tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status",       want.status,       m_axis_tuser);
                    check_field("slot",         want.slot,         m_axis_tdata[3:0]);
                    check_field("already_open", want.served,       m_axis_tdata[4]);
                    check_field("evicted",      want.evicted,      m_axis_tdata[5]);
                    check_field("evicted_slot", want.evicted_slot, m_axis_tdata[9:6]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic [OP_BITS-1:0] op, input logic [NUM_BITS-1:0] number,
                             input logic missing, input logic drain);
        slot_item_t it;
        it.op          = op;
        it.number      = number;
        it.missing     = missing;
        it.drain_first = drain;
        // only the first SLOTS defines land in the table
        if (op == OP_DEFINE && defines_queued < SLOTS) begin
            known_numbers.push_back(number);
            defines_queued++;
        end
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        open_limit_now = value;
    endtask

    // Mostly requests for defined numbers, a trickle of defines (the table
    // fills once and then reports full), some unknown or near-miss numbers,
    // a little op-3 noise, and clears only when asked.
    task automatic queue_random(input int count, input bit with_clears, input int drain_at);
        int                  n;
        int                  roll;
        int                  pick;
        logic [NUM_BITS-1:0] num;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (known_numbers.size() == 0) num = $urandom;
            else num = known_numbers[$urandom_range(known_numbers.size() - 1)];
            if (roll < 3) begin
                pick = $urandom_range(3);
                if (pick == 1 || pick == 2) num = $urandom;
                else if (pick == 3) num = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                push_item(OP_DEFINE, num, $urandom_range(4) == 0, n == drain_at);
            end else if (roll < 4) begin
                push_item(OP_UNUSED, $urandom, 1'($urandom_range(1)), n == drain_at);
            end else if (with_clears && roll < 7) begin
                push_item(OP_CLEAR, $urandom, 1'($urandom_range(1)), n == drain_at);
            end else begin
                pick = $urandom_range(19);
                if (pick == 0) num = $urandom;
                else if (pick == 1) num = num ^ (32'h1 << $urandom_range(31));
                push_item(OP_REQUEST, num, 1'($urandom_range(1)), n == drain_at);
            end
        end
    endtask

    task automatic run_phase(input logic [LIMIT_BITS-1:0] limit, input int send_pct,
                             input int recv_pct, input int count, input bit with_clears,
                             input int drain_at);
        wait_drained();
        write_limit(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(count, with_clears, drain_at);
    endtask

    initial begin
        int s;
        for (s = 0; s < SLOTS; s++) begin
            ent_number[s]  = '0;
            ent_used[s]    = 1'b0;
            ent_live[s]    = 1'b0;
            ent_missing[s] = 1'b0;
            ent_open[s]    = 1'b0;
            ent_uses[s]    = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, limit at its reset value of 4.
        push_item(OP_REQUEST, 32'h1234_5678, 1'b0, 1'b0);  // empty table: undefined
        push_item(OP_UNUSED,  32'hFFFF_FFFF, 1'b1, 1'b0);  // unused op: all-zero result
        push_item(OP_DEFINE,  32'h0000_0000, 1'b0, 1'b0);  // slot 0
        push_item(OP_DEFINE,  32'hFFFF_FFFF, 1'b1, 1'b0);  // slot 1, missing
        push_item(OP_DEFINE,  32'hA5A5_A5A5, 1'b0, 1'b0);  // slot 2
        push_item(OP_DEFINE,  32'hA5A5_A5A5, 1'b0, 1'b0);  // slot 3 shadows slot 2
        push_item(OP_DEFINE,  32'h5A5A_5A5A, 1'b0, 1'b0);  // slot 4
        push_item(OP_DEFINE,  32'h0000_FFFF, 1'b0, 1'b0);  // slot 5
        push_item(OP_DEFINE,  32'h1357_9BDF, 1'b0, 1'b0);  // slot 6
        push_item(OP_REQUEST, 32'hFFFF_FFFF, 1'b1, 1'b0);  // missing entry: served, not opened

        // Limit 0 with nothing open: open without a close, then a forced close.
        wait_drained();
        write_limit(5'd0);
        push_item(OP_REQUEST, 32'h0000_0000, 1'b0, 1'b0);
        push_item(OP_REQUEST, 32'hA5A5_A5A5, 1'b0, 1'b0);  // newest copy, closes slot 0

        // Back to 4: fill up, then a close where counts tie.
        wait_drained();
        write_limit(5'd4);
        push_item(OP_REQUEST, 32'h0000_0000, 1'b0, 1'b0);
        push_item(OP_REQUEST, 32'h0000_0000, 1'b1, 1'b0);  // already open
        push_item(OP_REQUEST, 32'h5A5A_5A5A, 1'b0, 1'b0);
        push_item(OP_REQUEST, 32'h0000_FFFF, 1'b0, 1'b0);
        push_item(OP_REQUEST, 32'h1357_9BDF, 1'b0, 1'b0);  // closes newest of the lowest count
        push_item(OP_REQUEST, 32'h7777_0000, 1'b0, 1'b0);  // unknown number

        // Random phases: limit extremes and out of range, each idling pattern.
        run_phase(5'd1,  0,  0,  350, 1'b0, -1);
        run_phase(5'd16, 71, 0,  350, 1'b0, -1);
        run_phase(5'd3,  0,  71, 350, 1'b0, -1);
        run_phase(5'd31, 32, 32, 350, 1'b0, -1);
        run_phase(5'd2,  0,  0,  350, 1'b0, 175);  // one mid-phase drain
        run_phase(5'd8,  32, 32, 150, 1'b1, -1);   // clears only in this last phase

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/luos_pkg.sv
rtl/luos_ram.sv
rtl/luos_cmp.sv
rtl/least_used_open_slot_policy_core.sv
verif/tb_least_used_open_slot_policy_core.sv
